[rtl/core/tgfw_pkg.sv]
// Shared constants, types and tables for the text glyph framebuffer writer.
// Holds screen geometry, command codes, the sequencer state type and the 5x7 font ROM.
// No dependencies.
package tgfw_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COUNT  = 59;
  localparam int CHAR_STEPS   = 2 * GLYPH_COLS;
  localparam int STEP_W       = 4;

  localparam logic [7:0] CURSOR_STEP   = 8'd6;
  localparam logic [7:0] GLYPH_FIRST   = 8'd32;
  localparam logic [7:0] GLYPH_LAST    = 8'd90;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [5:0]        glyph_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PIXEL  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_CHAR   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_RD,
    ST_CHAR,
    ST_DONE
  } state_t;

  // column 0 in the top byte, column 4 in the low byte; bit 0 is the top row
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543
  };

  function automatic glyph_t glyph_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - CASE_OFFSET;
    end
    if (c < GLYPH_FIRST || c > GLYPH_LAST) begin
      c = CHAR_QUESTION;
    end
    return glyph_t'(c - GLYPH_FIRST);
  endfunction

  function automatic logic [7:0] glyph_column(input glyph_t idx, input logic [2:0] col);
    logic [39:0] row_bits;
    row_bits = '0;
    if (32'(idx) < GLYPH_COUNT) begin
      row_bits = GLYPH_ROM[idx];
    end
    return row_bits[39 - 8 * int'(col) -: 8];
  endfunction

  function automatic addr_t frame_addr(input logic [7:0] x, input logic [4:0] page);
    return addr_t'(32'(x) + 32'(page) * SCREEN_WIDTH);
  endfunction

endpackage

[rtl/core/text_glyph_framebuffer_writer.sv]
// Page-organized monochrome framebuffer with text cursor and 5x7 glyph drawing.
// Frame memory, command sequencer and result register in one module.
// Depends on tgfw_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | command, pos_x, pos_y, pixel_on,
//           |           |                    | char_code, byte_index
//   out_    | output    | out_valid/out_stall| read_data, cursor_col, cursor_row
//
// One command at a time; the frame memory has one read and one write port, one byte each.
// Set cursor, unused codes, off-screen pixel and out-of-range read go straight to the result.
// Set pixel reads its byte and writes it back with the bit changed. Read byte reads one byte.
// Write character: ten read-modify-write slots overlapped through the port pair.
// Clear: the whole store is swept, one byte zeroed per cycle.
// After reset a sweep zeroes all STORE_BYTES bytes of the memory while in_stall stays high.
// A stalled result holds in the output register; the next command is taken meanwhile.
module text_glyph_framebuffer_writer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic       in_pixel_on,
  input  logic [7:0] in_char_code,
  input  logic [9:0] in_byte_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [7:0] out_cursor_col,
  output logic [7:0] out_cursor_row
);

  tgfw_pkg::state_t state_r, state_nxt;

  logic [7:0] frame_mem [tgfw_pkg::STORE_BYTES];
  logic [7:0] mem_q;

  logic                      rd_en, wr_en;
  tgfw_pkg::addr_t           rd_addr, wr_addr;
  logic [7:0]                wr_data;

  tgfw_pkg::addr_t           sweep_r, sweep_nxt;
  logic [tgfw_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [7:0]                text_col_r, text_col_nxt;
  logic [7:0]                text_row_r, text_row_nxt;

  logic [7:0]                px_r, py_r;
  logic                      on_r;
  tgfw_pkg::addr_t           idx_r;
  tgfw_pkg::glyph_t          glyph_r;
  logic                      rd_hit_r;

  logic                      pend_r, pend_nxt;
  tgfw_pkg::addr_t           pend_addr_r, pend_addr_nxt;
  logic [7:0]                pend_mask_r, pend_mask_nxt;

  logic                      out_valid_r;
  logic [7:0]                out_data_r, out_col_r, out_row_r;

  logic                      accept, out_free, sweep_last, pix_on_screen, read_in_range;

  logic [2:0]                st_col;
  logic                      st_sel;
  logic [7:0]                st_x, st_bits, st_mask, st_y6, st_yr;
  logic [4:0]                st_p0, st_p1, st_page;
  logic                      st_valid, step_done;

  assign accept        = in_valid && !in_stall;
  assign in_stall      = (state_r != tgfw_pkg::ST_IDLE);
  assign out_free      = !out_valid_r || !out_stall;
  assign sweep_last    = (sweep_r == tgfw_pkg::addr_t'(tgfw_pkg::STORE_BYTES - 1));
  assign pix_on_screen = (32'(in_pos_x) < tgfw_pkg::SCREEN_WIDTH) &&
                         (32'(in_pos_y) < tgfw_pkg::SCREEN_HEIGHT);
  assign read_in_range = (32'(in_byte_index) < tgfw_pkg::STORE_BYTES);
  assign step_done     = (32'(step_r) == tgfw_pkg::CHAR_STEPS);

  // glyph slot: two page halves per column
  always_comb begin
    st_col  = step_r[3:1];
    st_sel  = step_r[0];
    st_x    = text_col_r + 8'(st_col);
    st_bits = tgfw_pkg::glyph_column(glyph_r, st_col);
    st_y6   = text_row_r + 8'd6;
    st_p0   = text_row_r[7:3];
    st_p1   = st_y6[7:3];
    st_page = st_sel ? st_p1 : st_p0;
    st_mask = '0;
    st_yr   = '0;
    for (int r = 0; r < tgfw_pkg::GLYPH_ROWS; r++) begin
      st_yr = text_row_r + 8'(r);
      if (st_bits[r] && (32'(st_yr) < tgfw_pkg::SCREEN_HEIGHT) && (st_yr[7:3] == st_page)) begin
        st_mask[st_yr[2:0]] = 1'b1;
      end
    end
    st_valid = !step_done && (32'(st_x) < tgfw_pkg::SCREEN_WIDTH) && (st_mask != '0) &&
               (!st_sel || (st_p1 != st_p0));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tgfw_pkg::ST_INIT: begin
        if (sweep_last) state_nxt = tgfw_pkg::ST_IDLE;
      end
      tgfw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_command)
            tgfw_pkg::CMD_CLEAR: state_nxt = tgfw_pkg::ST_CLEAR;
            tgfw_pkg::CMD_PIXEL:
              state_nxt = pix_on_screen ? tgfw_pkg::ST_PIX_RD : tgfw_pkg::ST_DONE;
            tgfw_pkg::CMD_CHAR:  state_nxt = tgfw_pkg::ST_CHAR;
            tgfw_pkg::CMD_READ:
              state_nxt = read_in_range ? tgfw_pkg::ST_RD_RD : tgfw_pkg::ST_DONE;
            default:             state_nxt = tgfw_pkg::ST_DONE;
          endcase
        end
      end
      tgfw_pkg::ST_CLEAR: begin
        if (sweep_last) state_nxt = tgfw_pkg::ST_DONE;
      end
      tgfw_pkg::ST_PIX_RD: state_nxt = tgfw_pkg::ST_PIX_WR;
      tgfw_pkg::ST_PIX_WR: state_nxt = tgfw_pkg::ST_DONE;
      tgfw_pkg::ST_RD_RD:  state_nxt = tgfw_pkg::ST_DONE;
      tgfw_pkg::ST_CHAR: begin
        if (step_done) state_nxt = tgfw_pkg::ST_DONE;
      end
      tgfw_pkg::ST_DONE: begin
        if (out_free) state_nxt = tgfw_pkg::ST_IDLE;
      end
      default: state_nxt = tgfw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    sweep_nxt     = '0;
    step_nxt      = '0;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_mask_nxt = pend_mask_r;
    text_col_nxt  = text_col_r;
    text_row_nxt  = text_row_r;
    unique case (state_r) inside
      tgfw_pkg::ST_INIT, tgfw_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last) begin
          text_col_nxt = '0;
          text_row_nxt = '0;
        end
      end
      tgfw_pkg::ST_IDLE: begin
        if (accept && (in_command == tgfw_pkg::CMD_CURSOR)) begin
          text_col_nxt = in_pos_x;
          text_row_nxt = in_pos_y;
        end
      end
      tgfw_pkg::ST_PIX_RD: begin
        rd_en   = 1'b1;
        rd_addr = tgfw_pkg::frame_addr(px_r, py_r[7:3]);
      end
      tgfw_pkg::ST_PIX_WR: begin
        wr_en   = 1'b1;
        wr_addr = tgfw_pkg::frame_addr(px_r, py_r[7:3]);
        wr_data = on_r ? (mem_q | (8'd1 << py_r[2:0])) : (mem_q & ~(8'd1 << py_r[2:0]));
      end
      tgfw_pkg::ST_RD_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      tgfw_pkg::ST_CHAR: begin
        // read the next slot while the previous one writes back
        rd_en         = st_valid;
        rd_addr       = tgfw_pkg::frame_addr(st_x, st_page);
        pend_nxt      = st_valid;
        pend_addr_nxt = rd_addr;
        pend_mask_nxt = st_mask;
        wr_en         = pend_r;
        wr_addr       = pend_addr_r;
        wr_data       = mem_q | pend_mask_r;
        step_nxt      = step_r + 1'b1;
        if (step_done) text_col_nxt = text_col_r + tgfw_pkg::CURSOR_STEP;
      end
      tgfw_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgfw_pkg::ST_INIT;
      sweep_r     <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      text_col_r  <= '0;
      text_row_r  <= '0;
      out_valid_r <= 1'b0;
      rd_hit_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      step_r     <= step_nxt;
      pend_r     <= pend_nxt;
      text_col_r <= text_col_nxt;
      text_row_r <= text_row_nxt;
      if (accept) rd_hit_r <= (in_command == tgfw_pkg::CMD_READ) && read_in_range;
      if (state_r == tgfw_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
    if (accept) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      on_r    <= in_pixel_on;
      idx_r   <= tgfw_pkg::addr_t'(in_byte_index);
      glyph_r <= tgfw_pkg::glyph_index(in_char_code);
    end
    if (state_r == tgfw_pkg::ST_DONE && out_free) begin
      out_data_r <= rd_hit_r ? mem_q : 8'd0;
      out_col_r  <= text_col_r;
      out_row_r  <= text_row_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

  a_no_port_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same frame byte");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < tgfw_pkg::STORE_BYTES))
    else $error("frame write beyond the store");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == tgfw_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_clear_zeroes_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgfw_pkg::ST_DONE && $past(state_r) == tgfw_pkg::ST_CLEAR)
      |-> (text_col_r == 8'd0 && text_row_r == 8'd0))
    else $error("cursor not cleared by clear");

endmodule

[verif/tb.sv]
// Testbench for text_glyph_framebuffer_writer: directed and random commands with idling
// and back-pressure, replies checked against a mirrored frame store and cursor.
// Depends on tgfw_pkg and the text_glyph_framebuffer_writer RTL.
module tb;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 6000;
  localparam int TAIL_CYCLES  = 30;

  // column 0 in the top byte; bit 0 is the top row
  localparam logic [39:0] FONT_5X7 [59] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543
  };

  typedef struct {
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } reply_t;

  class page_frame_mirror;
    logic [7:0] frame [tgfw_pkg::STORE_BYTES];
    logic [7:0] text_col;
    logic [7:0] text_row;
    reply_t     replies_due [$];
    int         fail_count;

    function new();
      wipe();
      fail_count = 0;
    endfunction

    function void wipe();
      foreach (frame[i]) frame[i] = '0;
      text_col = '0;
      text_row = '0;
    endfunction

    function void plot(int x, int y, bit on);
      int addr;
      if (x >= tgfw_pkg::SCREEN_WIDTH || y >= tgfw_pkg::SCREEN_HEIGHT) return;
      addr = x + (y / 8) * tgfw_pkg::SCREEN_WIDTH;
      if (addr >= tgfw_pkg::STORE_BYTES) return;
      frame[addr][y % 8] = on;
    endfunction

    function void draw_glyph(logic [7:0] code);
      logic [7:0]  c;
      logic [39:0] cols;
      logic [7:0]  bits;
      int          g;
      c = code;
      if (c >= tgfw_pkg::CHAR_LOWER_A && c <= tgfw_pkg::CHAR_LOWER_Z)
        c = c - tgfw_pkg::CASE_OFFSET;
      if (c < tgfw_pkg::GLYPH_FIRST || c > tgfw_pkg::GLYPH_LAST) c = tgfw_pkg::CHAR_QUESTION;
      g = int'(c - tgfw_pkg::GLYPH_FIRST);
      cols = FONT_5X7[g];
      for (int col = 0; col < tgfw_pkg::GLYPH_COLS; col++) begin
        bits = cols[39 - 8 * col -: 8];
        for (int row = 0; row < tgfw_pkg::GLYPH_ROWS; row++) begin
          if (bits[row]) begin
            plot((int'(text_col) + col) % 256, (int'(text_row) + row) % 256, 1'b1);
          end
        end
      end
      text_col = text_col + tgfw_pkg::CURSOR_STEP;
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] x, logic [7:0] y, logic on,
                               logic [7:0] code, logic [9:0] idx);
      reply_t r;
      r.read_data = '0;
      case (cmd)
        tgfw_pkg::CMD_CLEAR:  wipe();
        tgfw_pkg::CMD_PIXEL:  plot(int'(x), int'(y), on);
        tgfw_pkg::CMD_CURSOR: begin
          text_col = x;
          text_row = y;
        end
        tgfw_pkg::CMD_CHAR:   draw_glyph(code);
        tgfw_pkg::CMD_READ:   if (int'(idx) < tgfw_pkg::STORE_BYTES) r.read_data = frame[idx];
        default:    ;
      endcase
      r.cursor_col = text_col;
      r.cursor_row = text_row;
      replies_due.push_back(r);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
    endtask

    task check_reply(logic [7:0] data, logic [7:0] col, logic [7:0] row);
      reply_t want;
      if (replies_due.size() == 0) begin
        flag_mismatch($sformatf("reply %0h/%0h/%0h with nothing outstanding", data, col, row));
        return;
      end
      want = replies_due.pop_front();
      if (data !== want.read_data)
        flag_mismatch($sformatf("read_data got %0h want %0h", data, want.read_data));
      if (col !== want.cursor_col)
        flag_mismatch($sformatf("cursor_col got %0h want %0h", col, want.cursor_col));
      if (row !== want.cursor_row)
        flag_mismatch($sformatf("cursor_row got %0h want %0h", row, want.cursor_row));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = '0;
  logic [7:0] in_pos_x = '0;
  logic [7:0] in_pos_y = '0;
  logic       in_pixel_on = 1'b0;
  logic [7:0] in_char_code = '0;
  logic [9:0] in_byte_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [7:0] out_cursor_col;
  logic [7:0] out_cursor_row;

  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  logic [9:0] last_pixel_idx = '0;
  page_frame_mirror sb;

  text_glyph_framebuffer_writer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_char_code   (in_char_code),
    .in_byte_index  (in_byte_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic issue_command(logic [2:0] cmd, logic [7:0] x, logic [7:0] y, logic on,
                               logic [7:0] code, logic [9:0] idx);
    if (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_pos_x      <= x;
    in_pos_y      <= y;
    in_pixel_on   <= on;
    in_char_code  <= code;
    in_byte_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(cmd, x, y, on, code, idx);
  endtask

  task automatic issue_random_command();
    logic [2:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] code;
    logic       on;
    logic [9:0] idx;
    int         pick;
    int         px;
    int         pg;
    pick = $urandom_range(0, 99);
    x    = 8'($urandom);
    y    = 8'($urandom);
    code = 8'($urandom);
    on   = 1'($urandom);
    idx  = 10'($urandom);
    if (pick < 2) begin
      cmd = tgfw_pkg::CMD_CLEAR;
    end else if (pick < 30) begin
      cmd = tgfw_pkg::CMD_PIXEL;
      if ($urandom_range(0, 99) < 80) begin
        x = 8'($urandom_range(0, tgfw_pkg::SCREEN_WIDTH - 1));
        y = 8'($urandom_range(0, tgfw_pkg::SCREEN_HEIGHT - 1));
      end
      if (int'(x) < tgfw_pkg::SCREEN_WIDTH && int'(y) < tgfw_pkg::SCREEN_HEIGHT)
        last_pixel_idx = 10'(int'(x) + (int'(y) / 8) * tgfw_pkg::SCREEN_WIDTH);
    end else if (pick < 42) begin
      cmd = tgfw_pkg::CMD_CURSOR;
      if ($urandom_range(0, 99) < 70) begin
        x = 8'($urandom_range(0, tgfw_pkg::SCREEN_WIDTH - 1));
        y = 8'($urandom_range(0, tgfw_pkg::SCREEN_HEIGHT - 1));
      end
    end else if (pick < 67) begin
      cmd = tgfw_pkg::CMD_CHAR;
      case ($urandom_range(0, 4))
        0, 1, 2: code = 8'($urandom_range(tgfw_pkg::GLYPH_FIRST, tgfw_pkg::GLYPH_LAST));
        3:       code = 8'($urandom_range(tgfw_pkg::CHAR_LOWER_A, tgfw_pkg::CHAR_LOWER_Z));
        default: ;
      endcase
    end else if (pick < 96) begin
      cmd = tgfw_pkg::CMD_READ;
      case ($urandom_range(0, 4))
        0, 1: begin
          px = int'((32'(sb.text_col) - $urandom_range(1, 6)) & 32'hFF);
          pg = ((int'(sb.text_row) + int'($urandom_range(0, 7))) % 256) / 8;
          if (px < tgfw_pkg::SCREEN_WIDTH && pg < tgfw_pkg::PAGE_COUNT)
            idx = 10'(px + pg * tgfw_pkg::SCREEN_WIDTH);
        end
        2: idx = last_pixel_idx;
        default: ;
      endcase
    end else begin
      cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    issue_command(cmd, x, y, on, code, idx);
  endtask

  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_reply(out_read_data, out_cursor_col, out_cursor_row);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (!steady && $urandom_range(0, 99) < 24);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("text_glyph_framebuffer_writer verification failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_command(tgfw_pkg::CMD_CLEAR,  8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd0,   8'd0,   1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd127, 8'd63,  1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd128, 8'd5,   1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd3,   8'd64,  1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd255, 8'd255, 1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1023);
    issue_command(tgfw_pkg::CMD_PIXEL,  8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h61, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h7A, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'hFF, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h5B, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd19);
    issue_command(tgfw_pkg::CMD_CURSOR, 8'd125, 8'd60,  1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h57, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1023);
    issue_command(tgfw_pkg::CMD_CURSOR, 8'd252, 8'd250, 1'b0, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_CHAR,   8'd0,   8'd0,   1'b0, 8'h42, 10'd0);
    issue_command(tgfw_pkg::CMD_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0);
    issue_command(CMD_SPARE_LO,         8'd0,   8'd0,   1'b1, 8'h00, 10'd0);
    issue_command(CMD_SPARE_HI,         8'd0,   8'd0,   1'b1, 8'h00, 10'd0);
    issue_command(tgfw_pkg::CMD_CLEAR,  8'd0,   8'd0,   1'b0, 8'h00, 10'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 200) wait_replies_drained();
      steady = (n >= 250 && n < 350);
      issue_random_command();
    end
    steady = 1'b0;

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d replies never arrived", sb.pending()));
    if (sb.fail_count == 0) begin
      $display("text_glyph_framebuffer_writer verification clean");
    end else begin
      $display("text_glyph_framebuffer_writer verification failed");
    end
    $finish;
  end
endmodule
